@@ hw/rtl/tcc_pkg.sv @@
// Shared types and constants for the text console cursor controller.
// Used by tcc_csr, tcc_step and text_console_cursor_control; no dependencies.
package tcc_pkg;

   localparam int POS_W      = 13;
   localparam int SIZE_W     = 14;
   localparam int COLOUR_W   = 24;
   localparam int CODE_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int CALC_W     = 16;
   localparam int TAB_SPACES = 4;
   localparam int LEFT_W     = $clog2(TAB_SPACES);

   // control character codes
   localparam logic [CODE_W-1:0] CODE_CR    = 8'd13;
   localparam logic [CODE_W-1:0] CODE_LF    = 8'd10;
   localparam logic [CODE_W-1:0] CODE_BS    = 8'd8;
   localparam logic [CODE_W-1:0] CODE_TAB   = 8'd9;
   localparam logic [CODE_W-1:0] CODE_SPACE = 8'd32;

   // register reset values
   localparam logic [SIZE_W-1:0]   WIDTH_RESET  = 14'd1024;
   localparam logic [SIZE_W-1:0]   HEIGHT_RESET = 14'd768;
   localparam logic [COLOUR_W-1:0] FG_RESET     = 24'h00FF88;
   localparam logic [COLOUR_W-1:0] BG_RESET     = 24'h0D0D0D;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCREEN_WIDTH  = 2'd0,
      CSR_SCREEN_HEIGHT = 2'd1,
      CSR_FG_COLOUR     = 2'd2,
      CSR_BG_COLOUR     = 2'd3
   } csr_idx_type;

   typedef enum logic {
      ACT_DRAW   = 1'b0,
      ACT_SCROLL = 1'b1
   } action_type;

   typedef struct packed {
      logic [SIZE_W-1:0]   screen_width;
      logic [SIZE_W-1:0]   screen_height;
      logic [COLOUR_W-1:0] fg;
      logic [COLOUR_W-1:0] bg;
   } csr_type;

   typedef struct packed {
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
   } cursor_type;

   typedef struct packed {
      action_type          action;
      logic [POS_W-1:0]    pos_x;
      logic [POS_W-1:0]    pos_y;
      logic [CODE_W-1:0]   glyph;
      logic [COLOUR_W-1:0] fg;
      logic [COLOUR_W-1:0] bg;
      logic                last;
   } cmd_type;

   typedef struct packed {
      logic              emit;
      cmd_type           cmd;
      cursor_type        cursor;
      logic              scroll_pending;
      logic [LEFT_W-1:0] left;
      logic              done;
   } step_type;

endpackage

@@ hw/rtl/tcc_csr.sv @@
// Configuration registers of the cursor controller: sizes and colours.
// Depends on tcc_pkg; raises a home pulse when a size register is written.
module tcc_csr
   import tcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output csr_type               csr,
   output logic                  home
);

   csr_type csr_ff, csr_in;
   logic    home_in;

   // decode the write
   always_comb begin
      csr_in  = csr_ff;
      home_in = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_SCREEN_WIDTH: begin
               csr_in.screen_width = csr_wr_data[SIZE_W-1:0];
               home_in = 1'b1;
            end
            CSR_SCREEN_HEIGHT: begin
               csr_in.screen_height = csr_wr_data[SIZE_W-1:0];
               home_in = 1'b1;
            end
            CSR_FG_COLOUR: begin
               csr_in.fg = csr_wr_data[COLOUR_W-1:0];
            end
            CSR_BG_COLOUR: begin
               csr_in.bg = csr_wr_data[COLOUR_W-1:0];
            end
            default: begin
               csr_in = csr_ff;
            end
         endcase
      end
   end

   // hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.screen_width  <= WIDTH_RESET;
         csr_ff.screen_height <= HEIGHT_RESET;
         csr_ff.fg            <= FG_RESET;
         csr_ff.bg            <= BG_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr  = csr_ff;
   assign home = home_in;

endmodule

@@ hw/rtl/tcc_step.sv @@
// One step of the cursor controller: at most one command and the next cursor.
// Depends on tcc_pkg; purely combinational, driven by the top-level registers.
module tcc_step
   import tcc_pkg::*;
#(
   parameter int FONT_WIDTH  = 8,
   parameter int FONT_HEIGHT = 16,
   parameter int MARGIN      = 4
) (
   input  logic [CODE_W-1:0] code,
   input  cursor_type        cursor,
   input  logic              scroll_pending,
   input  logic [LEFT_W-1:0] left,
   input  csr_type           csr,
   output step_type          step
);

   localparam logic signed [CALC_W-1:0] FW_S = CALC_W'(FONT_WIDTH);
   localparam logic signed [CALC_W-1:0] FH_S = CALC_W'(FONT_HEIGHT);
   localparam logic signed [CALC_W-1:0] M_S  = CALC_W'(MARGIN);
   localparam logic [POS_W-1:0]         FW_P = POS_W'(FONT_WIDTH);
   localparam logic [POS_W-1:0]         M_P  = POS_W'(MARGIN);

   logic [POS_W-1:0]         adv_col;
   logic [POS_W-1:0]         bs_col;
   logic                     wrap;
   logic signed [CALC_W-1:0] nl_row;
   logic signed [CALC_W-1:0] nl_row_fix;
   logic                     nl_scroll;
   logic [POS_W-1:0]         nl_row_out;
   logic                     pend;

   // advance one cell and check against the right margin
   assign adv_col = cursor.col + FW_P;
   assign bs_col  = cursor.col - FW_P;
   assign wrap    = ($signed(CALC_W'(adv_col)) + FW_S) >
                    ($signed(CALC_W'(csr.screen_width)) - M_S);

   // step down one text line and check against the bottom margin
   assign nl_row     = $signed(CALC_W'(cursor.row)) + FH_S;
   assign nl_scroll  = (nl_row + FH_S) > ($signed(CALC_W'(csr.screen_height)) - M_S);
   assign nl_row_fix = nl_scroll ? (nl_row - FH_S) : nl_row;
   assign nl_row_out = nl_row_fix[POS_W-1:0];

   assign pend = wrap && nl_scroll;

   always_comb begin
      step                = '0;
      step.cursor         = cursor;
      step.left           = left;
      step.cmd.action     = ACT_DRAW;
      step.cmd.bg         = csr.bg;
      step.scroll_pending = 1'b0;
      if (scroll_pending) begin
         // deliver the scroll left over from a wrapping draw
         step.emit       = 1'b1;
         step.cmd.action = ACT_SCROLL;
         step.done       = (left == '0);
         step.cmd.last   = (left == '0);
         if (left != '0) begin
            step.left = left - 1'b1;
         end
      end else begin
         case (code)
            CODE_CR: begin
               step.cursor.col = M_P;
               step.done       = 1'b1;
            end
            CODE_LF: begin
               step.cursor.col = M_P;
               step.cursor.row = nl_row_out;
               step.emit       = nl_scroll;
               step.cmd.action = ACT_SCROLL;
               step.cmd.last   = 1'b1;
               step.done       = 1'b1;
            end
            CODE_BS: begin
               step.done = 1'b1;
               if (cursor.col > M_P) begin
                  step.cursor.col = bs_col;
                  step.emit       = 1'b1;
                  step.cmd.pos_x  = bs_col;
                  step.cmd.pos_y  = cursor.row;
                  step.cmd.glyph  = CODE_SPACE;
                  step.cmd.fg     = csr.fg;
                  step.cmd.last   = 1'b1;
               end
            end
            default: begin
               // printable glyph, or one space of a tab
               step.emit      = 1'b1;
               step.cmd.pos_x = cursor.col;
               step.cmd.pos_y = cursor.row;
               step.cmd.glyph = (code == CODE_TAB) ? CODE_SPACE : code;
               step.cmd.fg    = csr.fg;
               if (wrap) begin
                  step.cursor.col = M_P;
                  step.cursor.row = nl_row_out;
               end else begin
                  step.cursor.col = adv_col;
               end
               step.scroll_pending = pend;
               if (!pend) begin
                  step.done     = (left == '0);
                  step.cmd.last = (left == '0);
                  if (left != '0) begin
                     step.left = left - 1'b1;
                  end
               end
            end
         endcase
      end
   end

endmodule

@@ hw/rtl/text_console_cursor_control.sv @@
// Top level of the text console cursor controller: request and result registers.
// Depends on tcc_pkg, tcc_csr and tcc_step.
//
//  channel | direction | ports                           | moves
//  req     | in        | req_valid/req_stall             | one character code per request
//  rsp     | out       | rsp_valid/rsp_stall             | one draw or scroll command
//  csr     | in        | csr_wr_en/csr_index/csr_wr_data | register write, no wait
//
// A request is held in the work register and one step a cycle, while the result
// register is empty or being taken, turns it into at most one command in the
// result register: CR, LF and backspace take one step, a plain glyph one step
// plus one for a wrap scroll, and a tab four draw steps plus one per scroll.
// Reset homes the cursor and loads the register defaults. A stalled result
// holds the step; a new request is taken while a result waits only when the
// work register is empty.
module text_console_cursor_control
   import tcc_pkg::*;
#(
   parameter int FONT_WIDTH  = 8,
   parameter int FONT_HEIGHT = 16,
   parameter int MARGIN      = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CODE_W-1:0]     req_glyph_code,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_action,
   output logic [POS_W-1:0]      rsp_pos_x,
   output logic [POS_W-1:0]      rsp_pos_y,
   output logic [CODE_W-1:0]     rsp_glyph,
   output logic [COLOUR_W-1:0]   rsp_fg_pixel,
   output logic [COLOUR_W-1:0]   rsp_bg_pixel,
   output logic                  rsp_last_of_run,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam logic [POS_W-1:0]  M_P       = POS_W'(MARGIN);
   localparam logic [LEFT_W-1:0] TAB_EXTRA = LEFT_W'(TAB_SPACES - 1);

   csr_type           csr;
   logic              home;
   step_type          step;

   logic              eng_valid_ff, eng_valid_in;
   logic [CODE_W-1:0] eng_code_ff, eng_code_in;
   logic [LEFT_W-1:0] eng_left_ff, eng_left_in;
   logic              eng_scroll_ff, eng_scroll_in;
   cursor_type        cursor_ff, cursor_in;
   logic              rsp_valid_ff, rsp_valid_in;
   cmd_type           rsp_cmd_ff, rsp_cmd_in;

   logic              rsp_free;
   logic              step_go;
   logic              req_accept;

   tcc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .csr         (csr),
      .home        (home)
   );

   tcc_step #(
      .FONT_WIDTH  (FONT_WIDTH),
      .FONT_HEIGHT (FONT_HEIGHT),
      .MARGIN      (MARGIN)
   ) u_step (
      .code           (eng_code_ff),
      .cursor         (cursor_ff),
      .scroll_pending (eng_scroll_ff),
      .left           (eng_left_ff),
      .csr            (csr),
      .step           (step)
   );

   // advance when the result slot is empty or being taken
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign step_go    = eng_valid_ff && rsp_free;
   assign req_stall  = eng_valid_ff && !(step_go && step.done);
   assign req_accept = req_valid && !req_stall;

   // next state of the work register, cursor and result register
   always_comb begin
      eng_valid_in  = eng_valid_ff;
      eng_code_in   = eng_code_ff;
      eng_left_in   = eng_left_ff;
      eng_scroll_in = eng_scroll_ff;
      cursor_in     = cursor_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_cmd_in    = rsp_cmd_ff;

      if (req_accept) begin
         eng_valid_in  = 1'b1;
         eng_code_in   = req_glyph_code;
         eng_left_in   = (req_glyph_code == CODE_TAB) ? TAB_EXTRA : '0;
         eng_scroll_in = 1'b0;
      end else if (step_go) begin
         eng_valid_in  = !step.done;
         eng_left_in   = step.left;
         eng_scroll_in = step.scroll_pending;
      end

      if (home) begin
         cursor_in.col = M_P;
         cursor_in.row = M_P;
      end else if (step_go) begin
         cursor_in = step.cursor;
      end

      if (step_go && step.emit) begin
         rsp_valid_in = 1'b1;
         rsp_cmd_in   = step.cmd;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // hold control state; payload registers need no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         eng_valid_ff  <= 1'b0;
         eng_scroll_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cursor_ff.col <= M_P;
         cursor_ff.row <= M_P;
      end else begin
         eng_valid_ff  <= eng_valid_in;
         eng_scroll_ff <= eng_scroll_in;
         rsp_valid_ff  <= rsp_valid_in;
         cursor_ff     <= cursor_in;
      end
      eng_code_ff <= eng_code_in;
      eng_left_ff <= eng_left_in;
      rsp_cmd_ff  <= rsp_cmd_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_action      = rsp_cmd_ff.action;
   assign rsp_pos_x       = rsp_cmd_ff.pos_x;
   assign rsp_pos_y       = rsp_cmd_ff.pos_y;
   assign rsp_glyph       = rsp_cmd_ff.glyph;
   assign rsp_fg_pixel    = rsp_cmd_ff.fg;
   assign rsp_bg_pixel    = rsp_cmd_ff.bg;
   assign rsp_last_of_run = rsp_cmd_ff.last;

   // a pending scroll only lives inside an active request
   a_scroll_in_request: assert property (@(posedge clock) disable iff (reset)
      eng_scroll_ff |-> eng_valid_ff)
      else $error("pending scroll without an active request");

   // a pending scroll step always produces a scroll command
   a_scroll_emits: assert property (@(posedge clock) disable iff (reset)
      (eng_valid_ff && eng_scroll_ff) |-> (step.emit && step.cmd.action == ACT_SCROLL))
      else $error("pending scroll step did not emit a scroll");

   // a size write puts the cursor at the padding corner
   a_home_cursor: assert property (@(posedge clock) disable iff (reset)
      home |=> (cursor_ff.col == M_P && cursor_ff.row == M_P))
      else $error("cursor not homed after a size write");

   // an emitted command always lands in the result register
   a_emit_lands: assert property (@(posedge clock) disable iff (reset)
      (step_go && step.emit) |=> rsp_valid_ff)
      else $error("emitted command lost");

endmodule

@@ dv/text_console_cursor_control_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for text_console_cursor_control: character requests in,
// draw and scroll commands checked against an in-bench cursor model. Depends on tcc_pkg.
module text_console_cursor_control_tb;
   import tcc_pkg::*;

   localparam int FONT_WIDTH    = 8;
   localparam int FONT_HEIGHT   = 16;
   localparam int MARGIN        = 4;
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int MAX_REPORTS   = 10;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CODE_W-1:0]     req_glyph_code = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_action;
   logic [POS_W-1:0]      rsp_pos_x;
   logic [POS_W-1:0]      rsp_pos_y;
   logic [CODE_W-1:0]     rsp_glyph;
   logic [COLOUR_W-1:0]   rsp_fg_pixel;
   logic [COLOUR_W-1:0]   rsp_bg_pixel;
   logic                  rsp_last_of_run;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_SCREEN_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   // cursor model state and the commands it still owes
   csr_type           model_csr;
   cursor_type        model_cursor;
   cmd_type           cmds_due[$];
   logic [CODE_W-1:0] codes_pending[$];
   int                send_idle_pct = 0;
   int                stall_pct = 0;
   int                mismatch_count = 0;
   int                cycle_count = 0;

   text_console_cursor_control #(
      .FONT_WIDTH  (FONT_WIDTH),
      .FONT_HEIGHT (FONT_HEIGHT),
      .MARGIN      (MARGIN)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_glyph_code  (req_glyph_code),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_action      (rsp_action),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_glyph       (rsp_glyph),
      .rsp_fg_pixel    (rsp_fg_pixel),
      .rsp_bg_pixel    (rsp_bg_pixel),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- cursor model

   task automatic home_cursor();
      model_cursor.col = POS_W'(MARGIN);
      model_cursor.row = POS_W'(MARGIN);
   endtask

   task automatic push_cmd(action_type act, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                           logic [CODE_W-1:0] code, logic [COLOUR_W-1:0] fg);
      cmd_type c;
      c.action = act;
      c.pos_x  = x;
      c.pos_y  = y;
      c.glyph  = code;
      c.fg     = fg;
      c.bg     = model_csr.bg;
      c.last   = 1'b0;
      cmds_due.push_back(c);
   endtask

   // Step down one text line; past the bottom, scroll and keep the row.
   task automatic line_feed();
      int row;
      row = int'(model_cursor.row) + FONT_HEIGHT;
      model_cursor.col = POS_W'(MARGIN);
      if (row + FONT_HEIGHT > int'(model_csr.screen_height) - MARGIN) begin
         push_cmd(ACT_SCROLL, '0, '0, '0, '0);
         row -= FONT_HEIGHT;
      end
      model_cursor.row = POS_W'(row);
   endtask

   // Draw at the cursor, advance one cell and wrap when the next cell would not fit.
   task automatic draw_glyph(logic [CODE_W-1:0] code);
      push_cmd(ACT_DRAW, model_cursor.col, model_cursor.row, code, model_csr.fg);
      model_cursor.col = POS_W'(int'(model_cursor.col) + FONT_WIDTH);
      if (int'(model_cursor.col) + FONT_WIDTH > int'(model_csr.screen_width) - MARGIN)
         line_feed();
   endtask

   task automatic predict_request(logic [CODE_W-1:0] code);
      int      first;
      cmd_type tail;
      first = cmds_due.size();
      case (code)
         CODE_CR: model_cursor.col = POS_W'(MARGIN);
         CODE_LF: line_feed();
         CODE_BS: begin
            // only step back when away from the left margin
            if (int'(model_cursor.col) > MARGIN) begin
               model_cursor.col = POS_W'(int'(model_cursor.col) - FONT_WIDTH);
               push_cmd(ACT_DRAW, model_cursor.col, model_cursor.row, CODE_SPACE,
                        model_csr.fg);
            end
         end
         CODE_TAB: repeat (TAB_SPACES) draw_glyph(CODE_SPACE);
         default: draw_glyph(code);
      endcase
      // flag the final command of this request
      if (cmds_due.size() > first) begin
         tail = cmds_due.pop_back();
         tail.last = 1'b1;
         cmds_due.push_back(tail);
      end
   endtask

   task automatic mirror_write(csr_idx_type idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_SCREEN_WIDTH: begin
            model_csr.screen_width = data[SIZE_W-1:0];
            home_cursor();
         end
         CSR_SCREEN_HEIGHT: begin
            model_csr.screen_height = data[SIZE_W-1:0];
            home_cursor();
         end
         CSR_FG_COLOUR: model_csr.fg = data[COLOUR_W-1:0];
         CSR_BG_COLOUR: model_csr.bg = data[COLOUR_W-1:0];
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------- driver

   // Drive requests from the pending queue and predict each one as it is taken.
   always @(posedge clock) begin : drive_requests
      logic              next_valid;
      logic [CODE_W-1:0] next_code;
      next_valid = req_valid;
      next_code  = req_glyph_code;
      if (reset) begin
         model_csr.screen_width  = WIDTH_RESET;
         model_csr.screen_height = HEIGHT_RESET;
         model_csr.fg            = FG_RESET;
         model_csr.bg            = BG_RESET;
         home_cursor();
         cmds_due.delete();
         next_valid = 1'b0;
      end else begin
         if (csr_wr_en)
            mirror_write(csr_idx_type'(csr_index), csr_wr_data);
         if (req_valid && !req_stall) begin
            predict_request(req_glyph_code);
            next_valid = 1'b0;
         end
         // hold a stalled request; otherwise maybe idle, else load the next one
         if (!next_valid && codes_pending.size() > 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            next_code  = codes_pending.pop_front();
            next_valid = 1'b1;
         end
      end
      req_valid      <= next_valid;
      req_glyph_code <= next_code;
   end

   // ---------------------------------------------------------------- monitor

   function automatic string cmd_text(cmd_type c);
      return $sformatf("act=%0d x=%0d y=%0d glyph=%h fg=%h bg=%h last=%0b",
                       c.action, c.pos_x, c.pos_y, c.glyph, c.fg, c.bg, c.last);
   endfunction

   task automatic note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("[%0d] %s", cycle_count, msg);
   endtask

   // Check each taken command against the oldest one owed, and stall at random.
   always @(posedge clock) begin : check_commands
      cmd_type got;
      cmd_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.action = action_type'(rsp_action);
         got.pos_x  = rsp_pos_x;
         got.pos_y  = rsp_pos_y;
         got.glyph  = rsp_glyph;
         got.fg     = rsp_fg_pixel;
         got.bg     = rsp_bg_pixel;
         got.last   = rsp_last_of_run;
         if (cmds_due.size() == 0) begin
            note_mismatch({"unexpected command: ", cmd_text(got)});
         end else begin
            want = cmds_due.pop_front();
            if (got.action !== want.action || got.pos_x !== want.pos_x ||
                got.pos_y !== want.pos_y || got.glyph !== want.glyph ||
                got.fg !== want.fg || got.bg !== want.bg || got.last !== want.last)
               note_mismatch({"command mismatch: expected ", cmd_text(want),
                              " actual ", cmd_text(got)});
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic write_reg(csr_idx_type idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Wait until every request is taken and every command is back, then let
   // requests that owe no command drain out of the block.
   task automatic wait_idle();
      @(negedge clock);
      while (codes_pending.size() > 0 || req_valid || cmds_due.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_codes(logic [CODE_W-1:0] codes[$]);
      @(negedge clock);
      foreach (codes[i])
         codes_pending.push_back(codes[i]);
   endtask

   // Control codes often, any byte otherwise.
   function automatic logic [CODE_W-1:0] random_code();
      case ($urandom_range(9))
         0: return CODE_CR;
         1: return CODE_LF;
         2: return CODE_BS;
         3: return CODE_TAB;
         default: return CODE_W'($urandom_range(255));
      endcase
   endfunction

   // Set geometry and colours, then send random requests in two bursts with a
   // full drain in between.
   task automatic run_phase(int idle_pct, int hold_pct, int width, int height, int count);
      write_reg(CSR_SCREEN_WIDTH, CSR_DATA_W'(width));
      write_reg(CSR_SCREEN_HEIGHT, CSR_DATA_W'(height));
      write_reg(CSR_FG_COLOUR, CSR_DATA_W'($urandom()));
      write_reg(CSR_BG_COLOUR, CSR_DATA_W'($urandom()));
      @(negedge clock);
      send_idle_pct = idle_pct;
      stall_pct     = hold_pct;
      repeat (count / 2) codes_pending.push_back(random_code());
      wait_idle();
      @(negedge clock);
      repeat (count - count / 2) codes_pending.push_back(random_code());
      wait_idle();
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // default geometry: glyph extremes, backspace down to and at the margin, tab
      queue_codes('{8'd65, 8'd0, 8'd255, CODE_BS, CODE_BS, CODE_BS, CODE_BS,
                    CODE_CR, CODE_TAB, CODE_LF, 8'd122});
      wait_idle();

      // small screen: every glyph wraps and every line feed scrolls;
      // size writes carry junk above the register width
      write_reg(CSR_SCREEN_WIDTH, 24'hFFC010);
      write_reg(CSR_SCREEN_HEIGHT, 24'h554010);
      write_reg(CSR_FG_COLOUR, 24'h000000);
      write_reg(CSR_BG_COLOUR, 24'hFFFFFF);
      queue_codes('{8'd97, CODE_TAB, CODE_LF, CODE_BS, CODE_CR, 8'd255});
      wait_idle();

      // zero sizes: comparisons go negative
      write_reg(CSR_SCREEN_WIDTH, 24'd0);
      write_reg(CSR_SCREEN_HEIGHT, 24'd0);
      queue_codes('{8'd65, CODE_TAB, CODE_LF});
      wait_idle();

      // random requests across idle and stall mixes and screen sizes
      run_phase(0, 0, 64, 48, 22);
      run_phase(66, 0, 16383, 8192, 22);
      run_phase(0, 66, 100, 100, 22);
      run_phase(28, 28, $urandom_range(16, 200), $urandom_range(16, 200), 22);

      if (mismatch_count == 0 && cmds_due.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
